>>> rtl/bgr_pkg.sv
// Package for the gradient GEMV and rank-1 update block.
// Holds payload structs, queue and memory sizes, register indexes and limits.
// No dependencies.
package bgr_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int ADDR_W      = $clog2(MAX_COLUMNS);
    localparam int FQ_DEPTH    = 4;
    localparam int FQ_PTR_W    = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W    = $clog2(FQ_DEPTH + 1);
    localparam int ACC_W       = 48;
    localparam int CFG_W       = 31;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CLIP   = 2'd1;

    localparam logic [CFG_W-1:0] LR_RESET   = 31'd655;
    localparam logic [CFG_W-1:0] CLIP_RESET = 31'd524288;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

    localparam logic signed [78:0] PROD_LIM = 79'sd4611686018427387904;
    localparam logic signed [47:0] DELTA_SAT = 48'sd70368744177664;

    typedef struct packed {
        logic signed [31:0] weight_in;
        logic signed [31:0] row_gradient;
        logic signed [31:0] activation;
        logic [9:0]         column;
        logic               first_row;
        logic               last_row;
        logic               want_input_grad;
    } t_in;

    typedef struct packed {
        logic signed [31:0] weight_out;
        logic signed [47:0] input_grad;
        logic               input_grad_valid;
    } t_out;

    typedef struct packed {
        t_in  item;
        logic g_zero;
        logic report;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_fq;

    typedef struct packed {
        logic [CFG_W-1:0] lr;
        logic [CFG_W-1:0] clip;
    } t_cfg;

endpackage

>>> rtl/bgr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bgr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bgr_front.sv
// Front end: accepts items, tags them for the back end and queues them.
// Depends on bgr_pkg.
module bgr_front import bgr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_in  i_item,
    input  logic i_pop,
    output logic o_full,
    output t_fq  o_head
);

    t_job                r_q [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wr_ptr;
    logic [FQ_PTR_W-1:0] r_rd_ptr;
    logic [FQ_CNT_W-1:0] r_cnt;
    t_job                n_job;

    always_comb begin
        n_job.item   = i_item;
        n_job.g_zero = (i_item.row_gradient == 32'sd0);
        n_job.report = i_item.want_input_grad & i_item.last_row;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_full     = (r_cnt == FQ_CNT_W'(FQ_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_q[r_rd_ptr];

endmodule

>>> rtl/bgr_back.sv
// Back end: sequencer for the accumulator update and the clamped weight update,
// plus the post-reset clearing pass. Depends on bgr_pkg and bgr_ram.
module bgr_back import bgr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  t_fq  i_head,
    output logic o_pop,
    output logic o_clr_busy,
    output logic o_res_valid,
    output t_out o_res,
    input  logic i_res_ready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GW   = 3'd1;
    localparam logic [2:0] S_LG   = 3'd2;
    localparam logic [2:0] S_SH   = 3'd3;
    localparam logic [2:0] S_SL   = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;

    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic                    r_clr_busy;
    logic [ADDR_W-1:0]       r_clr_addr;
    t_job                    r_job;
    logic signed [63:0]      r_pgw;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [62:0]      r_plg;
    logic signed [62:0]      r_phi;
    logic signed [48:0]      r_plo;
    logic signed [78:0]      r_p;
    logic signed [ACC_W-1:0] r_grad;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [ACC_W-1:0]        ram_wdata;
    logic [ACC_W-1:0]        ram_rdata;

    logic signed [47:0]      term;
    logic signed [48:0]      sum_wide;
    logic signed [ACC_W-1:0] sum_sat;
    logic signed [63:0]      plg_full;
    logic signed [46:0]      step;
    logic signed [78:0]      p_sum;
    logic signed [47:0]      delta;
    logic signed [49:0]      new_w;
    logic signed [49:0]      clip_pos;
    logic signed [31:0]      w_clamped;

    bgr_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_COLUMNS)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_head.job.item.column[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_pop      = (r_state == S_IDLE) && i_head.valid && !r_clr_busy;
    assign o_clr_busy = r_clr_busy;

    always_comb begin
        term     = r_pgw[63:16];
        sum_wide = 49'(r_acc) + 49'(term);
        if (sum_wide[48] != sum_wide[47]) begin
            sum_sat = sum_wide[48] ? ACC_MIN : ACC_MAX;
        end else begin
            sum_sat = sum_wide[47:0];
        end
    end

    always_comb begin
        plg_full = $signed({1'b0, i_cfg.lr}) * $signed(r_job.item.row_gradient);
        step     = r_plg[62:16];
        p_sum    = $signed({r_phi, 16'b0}) + $signed({{30{r_plo[48]}}, r_plo});
    end

    always_comb begin
        if (r_p > PROD_LIM || r_p < -PROD_LIM) begin
            delta = r_p[78] ? -DELTA_SAT : DELTA_SAT;
        end else begin
            delta = r_p[63:16];
        end
        new_w    = 50'(r_job.item.weight_in) - 50'(delta);
        clip_pos = $signed({19'b0, i_cfg.clip});
        if (new_w > clip_pos) begin
            w_clamped = clip_pos[31:0];
        end else if (new_w < -clip_pos) begin
            w_clamped = 32'(-clip_pos);
        end else begin
            w_clamped = new_w[31:0];
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == S_LG) &&
                        (r_job.item.first_row || r_job.item.want_input_grad);
            ram_waddr = r_job.item.column[ADDR_W-1:0];
            ram_wdata = r_job.item.want_input_grad ? sum_sat : '0;
        end
    end

    always_comb begin
        o_res_valid = (r_state == S_UPD);
        if (i_cfg.lr == '0 || r_job.g_zero) begin
            o_res.weight_out = r_job.item.weight_in;
        end else begin
            o_res.weight_out = w_clamped;
        end
        o_res.input_grad       = r_job.report ? r_grad : '0;
        o_res.input_grad_valid = r_job.report;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_GW;
                end
            end
            S_GW:  n_state = S_LG;
            S_LG:  n_state = S_SH;
            S_SH:  n_state = S_SL;
            S_SL:  n_state = S_SUM;
            S_SUM: n_state = S_UPD;
            S_UPD: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(MAX_COLUMNS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head.job;
        end
        if (r_state == S_GW) begin
            r_pgw <= $signed(r_job.item.row_gradient) * $signed(r_job.item.weight_in);
            r_acc <= r_job.item.first_row ? '0 : $signed(ram_rdata);
        end
        if (r_state == S_LG) begin
            r_plg  <= plg_full[62:0];
            r_grad <= sum_sat;
        end
        if (r_state == S_SH) begin
            r_phi <= $signed(step[46:16]) * $signed(r_job.item.activation);
        end
        if (r_state == S_SL) begin
            r_plo <= $signed({1'b0, step[15:0]}) * $signed(r_job.item.activation);
        end
        if (r_state == S_SUM) begin
            r_p <= p_sum;
        end
    end

endmodule

>>> rtl/backprop_gemv_rank1_update.sv
// Top level of the gradient GEMV and rank-1 update block.
// Holds the configuration registers and the result register.
// Depends on bgr_pkg, bgr_front, bgr_back.
//
// Usage:
//   Input channel: drive i_item and raise push; the transaction is taken at an
//   edge where push is high and full is low. Items come in row-major order.
//   Result channel: while empty is low, o_result holds the oldest result; it is
//   taken at an edge where pop is high. Each item gives exactly one result.
//   Configuration: i_cfg_we with i_cfg_idx and i_cfg_data writes a register;
//   write only while the block is idle.
//   The back-end sequencer steps each item through the multiply path and the
//   accumulator RAM and takes no new item until it is through with the last.
//   A 4-entry input queue takes items while the back end works, and the result
//   register lets the back end work on the next item while a result waits.
//   Reset: synchronous, active low. After reset the accumulator RAM is cleared
//   one entry per cycle over all 1024 entries, and full stays high during that pass.
//   A stalled receiver holds the result register; the back end then waits and
//   the input queue fills until full rises.
module backprop_gemv_rank1_update import bgr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_in                  i_item,
    output logic                 empty,
    input  logic                 pop,
    output t_out                 o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg r_cfg;
    logic r_out_vld;
    t_out r_out;

    logic front_full;
    logic push_acc;
    logic pop_acc;
    t_fq  head;
    logic back_pop;
    logic clr_busy;
    logic res_valid;
    t_out res;
    logic res_ready;

    assign full     = front_full | clr_busy;
    assign push_acc = push & !full;
    assign pop_acc  = pop & r_out_vld;
    assign res_ready = !r_out_vld || pop_acc;
    assign empty    = !r_out_vld;
    assign o_result = r_out;

    bgr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_acc),
        .i_item  (i_item),
        .i_pop   (back_pop),
        .o_full  (front_full),
        .o_head  (head)
    );

    bgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .o_pop       (back_pop),
        .o_clr_busy  (clr_busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lr   <= LR_RESET;
            r_cfg.clip <= CLIP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LEARNING_RATE: r_cfg.lr   <= i_cfg_data;
                REG_WEIGHT_CLIP:   r_cfg.clip <= i_cfg_data;
                default:           r_cfg      <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (pop_acc) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_pop |-> head.valid)
        else $error("back end took an item from an empty queue");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !res_valid)
        else $error("result produced during the clearing pass");

    a_grad_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.input_grad_valid) |-> (o_result.input_grad == '0))
        else $error("input gradient nonzero without valid flag");

    a_full_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> full)
        else $error("input taken before the clearing pass");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for backprop_gemv_rank1_update: weight elements stream in through
// the push side, each update is predicted locally and compared on the pop side.
// Depends on bgr_pkg and the backprop_gemv_rank1_update RTL.
module tb_top;
    import bgr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] Q_LSB_NEG = 32'hFFFF_FFFF;

    localparam logic [CFG_W-1:0] RATE_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam longint GRAD_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint GRAD_MIN  = -GRAD_MAX - 1;
    localparam longint DELTA_CAP = 64'sd1 <<< 46;
    localparam logic signed [127:0] STEP_PROD_LIMIT = 128'sd1 <<< 62;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    t_in i_item = '0;
    logic empty;
    logic pop = 1'b0;
    t_out o_result;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    logic [CFG_W-1:0] rate_lr = LR_RESET;
    logic [CFG_W-1:0] rate_clip = CLIP_RESET;
    logic signed [ACC_W-1:0] grad_acc [MAX_COLUMNS];
    t_out awaited_updates [$];

    bit idle_en = 1'b1;
    int rx_hold_req = 0;
    int rx_hold_left = 0;
    int cycles = 0;
    int n_items = 0;
    int n_checked = 0;
    int n_grad_reports = 0;
    int n_settings = 0;
    int n_mismatch = 0;
    int n_leftover = 0;

    backprop_gemv_rank1_update dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d updates outstanding", cycles,
                     awaited_updates.size());
            $display("backprop_gemv_rank1_update: mismatch");
            $finish;
        end
    end

    function automatic t_out compute_update(input t_in it);
        longint w, g, x, s, d, nw, acc_sum, clip_v;
        logic signed [127:0] prod, prod_mag;
        t_out r;
        w = longint'($signed(it.weight_in));
        g = longint'($signed(it.row_gradient));
        x = longint'($signed(it.activation));
        r = '0;
        if (it.first_row) begin
            grad_acc[it.column] = '0;
        end
        if (it.want_input_grad) begin
            acc_sum = longint'(grad_acc[it.column]);
            acc_sum = acc_sum + ((g * w) >>> 16);
            if (acc_sum > GRAD_MAX) begin
                acc_sum = GRAD_MAX;
            end else if (acc_sum < GRAD_MIN) begin
                acc_sum = GRAD_MIN;
            end
            grad_acc[it.column] = acc_sum[47:0];
            if (it.last_row) begin
                r.input_grad = acc_sum[47:0];
                r.input_grad_valid = 1'b1;
            end
        end
        if (rate_lr == '0 || g == 0) begin
            r.weight_out = it.weight_in;
        end else begin
            s = (longint'(rate_lr) * g) >>> 16;
            prod = 128'(s);
            prod = prod * 128'(x);
            prod_mag = (prod < 0) ? -prod : prod;
            if (prod_mag > STEP_PROD_LIMIT) begin
                d = (prod < 0) ? -DELTA_CAP : DELTA_CAP;
            end else begin
                d = longint'(prod >>> 16);
            end
            clip_v = longint'(rate_clip);
            nw = w - d;
            if (nw > clip_v) begin
                nw = clip_v;
            end else if (nw < -clip_v) begin
                nw = -clip_v;
            end
            r.weight_out = nw[31:0];
        end
        return r;
    endfunction

    function automatic t_in mk_elem(input logic [31:0] w, g, x, input int col,
                                    input bit is_first, is_last, is_want);
        t_in it;
        it.weight_in = w;
        it.row_gradient = g;
        it.activation = x;
        it.column = col[9:0];
        it.first_row = is_first;
        it.last_row = is_last;
        it.want_input_grad = is_want;
        return it;
    endfunction

    function automatic logic [31:0] pick_q16();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = Q_MAX;
            1: v = Q_MIN;
            2: v = '0;
            3, 4, 5: v = $urandom;
            default: begin
                v = $urandom_range(0, 32'h0008_0000);
                v = v - 32'h0004_0000;
            end
        endcase
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_rate();
        logic [CFG_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = RATE_MAX;
            2: v = LR_RESET;
            3: v = CLIP_RESET;
            4: v = CFG_W'($urandom_range(1, 32'h0002_0000));
            default: v = CFG_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic check_result(input t_out got);
        t_out exp_r;
        if (awaited_updates.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= REPORT_MAX) begin
                $display("unexpected update: w=%h grad=%h valid=%b", got.weight_out,
                         got.input_grad, got.input_grad_valid);
            end
        end else begin
            exp_r = awaited_updates.pop_front();
            n_checked++;
            if (exp_r.input_grad_valid) begin
                n_grad_reports++;
            end
            if (got.weight_out !== exp_r.weight_out || got.input_grad !== exp_r.input_grad
                    || got.input_grad_valid !== exp_r.input_grad_valid) begin
                n_mismatch++;
                if (n_mismatch <= REPORT_MAX) begin
                    $display("update %0d: expected w=%h grad=%h valid=%b, got w=%h grad=%h valid=%b",
                             n_checked, exp_r.weight_out, exp_r.input_grad,
                             exp_r.input_grad_valid, got.weight_out, got.input_grad,
                             got.input_grad_valid);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                check_result(o_result);
            end
            if (rx_hold_req != 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= !(idle_en && $urandom_range(0, 99) < 19);
            end
        end
    end

    task automatic push_element(input t_in it);
        if (idle_en && $urandom_range(0, 99) < 19) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 19);
        end
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        awaited_updates.push_back(compute_update(it));
        n_items++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (awaited_updates.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_rates(input logic [CFG_W-1:0] lr, input logic [CFG_W-1:0] clip);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_LEARNING_RATE;
        i_cfg_data <= lr;
        @(posedge i_clk);
        rate_lr = lr;
        i_cfg_idx <= REG_WEIGHT_CLIP;
        i_cfg_data <= clip;
        @(posedge i_clk);
        rate_clip = clip;
        i_cfg_idx <= $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
        i_cfg_data <= CFG_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic test_edge_values();
        push_element(mk_elem(Q_MAX, Q_MIN, Q_MIN, 0, 1, 1, 1));
        push_element(mk_elem(Q_MIN, Q_MIN, Q_MAX, MAX_COLUMNS - 1, 1, 1, 1));
        push_element(mk_elem(Q_MIN, Q_MAX, Q_MIN, 512, 1, 1, 0));
        push_element(mk_elem(Q_MAX, '0, 32'h0000_3039, 3, 1, 1, 1));
        push_element(mk_elem(Q_MAX, 32'h0000_0001, Q_MAX, 4, 1, 1, 1));
        push_element(mk_elem(Q_MIN, Q_LSB_NEG, Q_ONE, 4, 1, 0, 1));
    endtask

    task automatic test_gradient_accumulation();
        push_element(mk_elem(Q_MIN, Q_MIN, Q_ONE, 5, 1, 0, 1));
        push_element(mk_elem(Q_MIN, Q_MIN, Q_ONE, 5, 0, 0, 1));
        push_element(mk_elem(Q_MIN, Q_MIN, Q_ONE, 5, 0, 0, 1));
        push_element(mk_elem(Q_MIN, Q_MIN, Q_ONE, 5, 0, 1, 1));
        push_element(mk_elem(Q_MAX, Q_MIN, Q_ONE, 6, 1, 0, 1));
        push_element(mk_elem(Q_MAX, Q_MIN, Q_ONE, 6, 0, 0, 1));
        push_element(mk_elem(Q_MAX, Q_MIN, Q_ONE, 6, 0, 1, 1));
        push_element(mk_elem(Q_ONE, 32'h0003_0000, Q_ONE, 9, 1, 0, 1));
        push_element(mk_elem(Q_ONE, 32'h0003_0000, Q_ONE, 9, 1, 0, 0));
        push_element(mk_elem(Q_ONE, Q_ONE, Q_ONE, 9, 0, 1, 1));
        push_element(mk_elem(Q_NEG_ONE, 32'h0002_0000, Q_ONE, 8, 1, 0, 1));
        push_element(mk_elem(Q_NEG_ONE, 32'h0002_0000, Q_ONE, 8, 0, 1, 0));
    endtask

    task automatic test_config_extremes();
        program_rates('0, '0);
        push_element(mk_elem(Q_MAX, Q_MIN, Q_ONE, 20, 1, 1, 1));
        push_element(mk_elem(32'h0003_0000, Q_ONE, 32'h0002_0000, 21, 1, 1, 1));
        program_rates(RATE_MAX, '0);
        push_element(mk_elem(Q_ONE, Q_ONE, Q_ONE, 22, 1, 1, 1));
        program_rates(RATE_MAX, RATE_MAX);
        push_element(mk_elem(Q_MIN, Q_MAX, Q_MAX, 23, 1, 1, 1));
        push_element(mk_elem(Q_ONE, Q_NEG_ONE, 32'h0002_0000, 23, 0, 1, 1));
    endtask

    task automatic test_random_matrices(input int count);
        int done_items, rows, cols, base;
        bit grad_on;
        logic [31:0] acts [8];
        logic [31:0] row_g;
        done_items = 0;
        while (done_items < count) begin
            if ($urandom_range(0, 99) < 15) begin
                push_element(mk_elem(pick_q16(), pick_q16(), pick_q16(),
                                     $urandom_range(0, MAX_COLUMNS - 1),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1))));
                done_items++;
            end else begin
                rows = $urandom_range(1, 6);
                cols = $urandom_range(1, 8);
                base = $urandom_range(0, MAX_COLUMNS - cols);
                grad_on = ($urandom_range(0, 9) != 0);
                for (int c = 0; c < cols; c++) begin
                    acts[c] = pick_q16();
                end
                for (int r = 0; r < rows; r++) begin
                    row_g = pick_q16();
                    for (int c = 0; c < cols; c++) begin
                        push_element(mk_elem(pick_q16(), row_g, acts[c], base + c, r == 0,
                                             r == rows - 1, grad_on));
                    end
                end
                done_items += rows * cols;
            end
        end
    endtask

    task automatic test_streaming();
        idle_en = 1'b0;
        program_rates(LR_RESET, CLIP_RESET);
        test_random_matrices(150);
        drain();
        idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        program_rates(pick_rate(), pick_rate());
        rx_hold_req = 300;
        test_random_matrices(60);
        drain();
    endtask

    initial begin
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            grad_acc[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);

        test_edge_values();
        test_gradient_accumulation();
        test_config_extremes();
        repeat (4) begin
            program_rates(pick_rate(), pick_rate());
            test_random_matrices(180);
        end
        test_streaming();
        test_backpressure();

        drain();
        idle_en = 1'b0;
        repeat (20) @(posedge i_clk);
        n_leftover = awaited_updates.size();

        $display("streamed %0d weight elements under %0d rate settings, %0d updates checked",
                 n_items, n_settings, n_checked);
        $display("%0d finished input gradients reported, %0d failures",
                 n_grad_reports, n_mismatch + n_leftover);
        if (n_mismatch == 0 && n_leftover == 0) begin
            $display("backprop_gemv_rank1_update: match");
        end else begin
            $display("backprop_gemv_rank1_update: mismatch");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/bgr_pkg.sv
rtl/bgr_ram.sv
rtl/bgr_front.sv
rtl/bgr_back.sv
rtl/backprop_gemv_rank1_update.sv
bench/tb_top.sv
